// ===== src/rsmoe_pkg.sv =====
`default_nettype none
package rsmoe_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 33;
  localparam int THR_W    = 30;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_RAISE  = 2'd1;
  localparam logic [1:0] MODE_LOWER  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BELOW     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [29:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [10:0]        entry_count;
    logic [31:0]        evicted_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_EV_RD,
    S_EV_CHK,
    S_Q_CHK,
    S_OUT
  } state_t;

  // logical slot to physical address in the ring
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] hd,
                                             input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - ADDR_W){1'b0}}, hd} + {1'b0, idx};
    if (s >= (CNT_W + 1)'(CAPACITY)) s = s - (CNT_W + 1)'(CAPACITY);
    return s[ADDR_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/rank_select_multiset_offset_evict.sv =====
// channel | ports                      | transfer when
// in      | in_valid in_stall in_data   | in_valid && !in_stall
// out     | out_valid out_stall out_data| out_valid && !out_stall
// cfg     | cfg_we cfg_wdata            | cfg_we
// values sit ascending in a ring buffer in one single-port ram with a registered read
// insert: each larger entry is read and shifted up one slot from the top, then the new value is written
// offset change: binary search for the first entry at or above the threshold, then eviction below it
// query: one ram read, none for a missing rank or a rejected insert; eviction advances the head
// reset is synchronous and clears count, offset, counter and threshold, not the ram
// the next item is taken while a finished result still waits on out_stall
`default_nettype none
module rank_select_multiset_offset_evict (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rsmoe_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rsmoe_pkg::out_item_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [29:0]          cfg_wdata
);
  import rsmoe_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] hd_r, hd_nxt;
  logic signed [31:0] off_r, off_nxt;
  logic [31:0] evc_r, evc_nxt;
  logic [THR_W-1:0] thr_r;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [1:0] st_r, st_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VAL_W-1:0] mem_wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  logic signed [VAL_W-1:0] rd_s;
  logic signed [33:0] adj, off_sum, thr_s;
  logic [CNT_W-1:0] mid;
  logic [32:0] evc_sum;

  always_comb begin
    rd_s    = signed'(rdata_r);
    adj     = {rd_s[VAL_W-1], rd_s} + {{2{off_r[31]}}, off_r};
    thr_s   = {4'b0, thr_r};
    mid     = CNT_W'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
    evc_sum = {1'b0, evc_r} + {{(33 - CNT_W){1'b0}}, lo_r};
    if (in_data.mode == MODE_LOWER)
      off_sum = {{2{off_r[31]}}, off_r} - {4'b0, in_data.operand};
    else
      off_sum = {{2{off_r[31]}}, off_r} + {4'b0, in_data.operand};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    hd_nxt = hd_r;
    off_nxt = off_r;
    evc_nxt = evc_r;
    val_nxt = val_r;
    pos_nxt = pos_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    res_nxt = res_r;
    st_nxt = st_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = phys(hd_r, pos_r);
    mem_raddr = phys(hd_r, pos_r - CNT_W'(1));
    mem_wdata = val_r;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          st_nxt = ST_OK;
          unique case (in_data.mode) inside
            MODE_INSERT: begin
              val_nxt = {3'b0, in_data.operand} - {off_r[31], off_r};
              pos_nxt = cnt_r;
              if (in_data.operand < thr_r) begin
                st_nxt = ST_BELOW;
                state_nxt = S_OUT;
              end else if (cnt_r == CNT_W'(CAPACITY)) begin
                st_nxt = ST_FULL;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            MODE_RAISE, MODE_LOWER: begin
              off_nxt = sat32(off_sum);
              lo_nxt = '0;
              hi_nxt = cnt_r;
              state_nxt = S_EV_RD;
            end
            default: begin
              if (in_data.operand == '0 ||
                  in_data.operand > {{(30 - CNT_W){1'b0}}, cnt_r}) begin
                res_nxt = -32'sd1;
                st_nxt = ST_NOT_FOUND;
                state_nxt = S_OUT;
              end else begin
                mem_re = 1'b1;
                mem_raddr = phys(hd_r, cnt_r - in_data.operand[CNT_W-1:0]);
                state_nxt = S_Q_CHK;
              end
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (pos_r == '0) begin
          mem_we = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_OUT;
        end else begin
          mem_re = 1'b1;
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (rd_s > val_r) begin
          // larger entry moves up one slot
          mem_wdata = rdata_r;
          pos_nxt = pos_r - CNT_W'(1);
          state_nxt = S_INS_RD;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = S_OUT;
        end
      end
      S_EV_RD: begin
        if (lo_r == hi_r) begin
          hd_nxt = phys(hd_r, lo_r);
          cnt_nxt = cnt_r - lo_r;
          evc_nxt = evc_sum[32] ? 32'hFFFFFFFF : evc_sum[31:0];
          state_nxt = S_OUT;
        end else begin
          mem_re = 1'b1;
          mem_raddr = phys(hd_r, mid);
          pos_nxt = mid;
          state_nxt = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (adj < thr_s) lo_nxt = pos_r + CNT_W'(1);
        else hi_nxt = pos_r;
        state_nxt = S_EV_RD;
      end
      S_Q_CHK: begin
        res_nxt = sat32(adj);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.result_value = res_r;
          out_data_nxt.status = st_r;
          out_data_nxt.entry_count = 11'(cnt_r);
          out_data_nxt.evicted_total = evc_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      hd_r <= '0;
      off_r <= '0;
      evc_r <= '0;
      thr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      hd_r <= hd_nxt;
      off_r <= off_nxt;
      evc_r <= evc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    res_r <= res_nxt;
    st_r <= st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY)) else $error("count above capacity");
  a_evc_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> evc_r >= $past(evc_r)) else $error("eviction total fell");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == S_IDLE) else $error("result loaded mid-op");
  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS_CHK |-> pos_r != '0) else $error("shift below slot zero");
  a_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_RD || state_r == S_EV_CHK) |-> lo_r <= hi_r && hi_r <= cnt_r)
    else $error("search bounds broken");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_rank_select_multiset_offset_evict.sv =====
`default_nettype none
module tb_rank_select_multiset_offset_evict;
  timeunit 1ns;
  timeprecision 1ps;
  import rsmoe_pkg::*;

  localparam int MAX_CYCLES = 20000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [29:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  rank_select_multiset_offset_evict u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state: stored values ascending, adjusted by the offset
  longint store_vals[$];
  longint offset_acc;
  longint unsigned evict_cnt;
  longint thresh;
  out_item_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_recv = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_off = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  longint cycles = 0;
  logic ov_pre = 1'b0;
  out_item_t od_pre = '0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void drop_below_threshold();
    int n;
    n = 0;
    while (store_vals.size() > 0 && store_vals[0] + offset_acc < thresh) begin
      void'(store_vals.pop_front());
      n++;
    end
    evict_cnt = evict_cnt + n;
    if (evict_cnt > 64'hFFFF_FFFF) evict_cnt = 64'hFFFF_FFFF;
  endfunction

  function automatic out_item_t predict_multiset(in_item_t it);
    out_item_t r;
    longint op;
    longint v;
    int pos;
    op = longint'(it.operand);
    r = '0;
    case (it.mode)
      MODE_INSERT: begin
        if (op < thresh) r.status = ST_BELOW;
        else if (store_vals.size() >= CAPACITY) r.status = ST_FULL;
        else begin
          v = op - offset_acc;
          pos = store_vals.size();
          while (pos > 0 && store_vals[pos-1] > v) pos--;
          store_vals.insert(pos, v);
        end
      end
      MODE_RAISE: begin
        offset_acc = clamp32(offset_acc + op);
        drop_below_threshold();
      end
      MODE_LOWER: begin
        offset_acc = clamp32(offset_acc - op);
        drop_below_threshold();
      end
      default: begin
        if (op == 0 || op > store_vals.size()) begin
          r.result_value = -32'sd1;
          r.status = ST_NOT_FOUND;
        end else begin
          r.result_value = 32'(clamp32(store_vals[store_vals.size() - op] + offset_acc));
        end
      end
    endcase
    r.entry_count = 11'(store_vals.size());
    r.evicted_total = 32'(evict_cnt);
    return r;
  endfunction

  // outputs only move at the rising edge, so this copy holds their value at the next one
  always @(negedge clk) begin
    ov_pre = out_valid;
    od_pre = out_data;
  end

  // receiver side
  always @(posedge clk) begin
    if (rst_n && ov_pre && !out_stall) begin
      n_recv <= n_recv + 1;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (od_pre.result_value !== e.result_value) begin
          $error("result_value: expected %0d actual %0d", e.result_value,
                 od_pre.result_value);
          errors++;
        end
        if (od_pre.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, od_pre.status);
          errors++;
        end
        if (od_pre.entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d actual %0d", e.entry_count,
                 od_pre.entry_count);
          errors++;
        end
        if (od_pre.evicted_total !== e.evicted_total) begin
          $error("evicted_total: expected %0d actual %0d", e.evicted_total,
                 od_pre.evicted_total);
          errors++;
        end
      end
    end
  end

  // stall drive, with a long hold-off counted here
  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // one transfer on the input channel; the expectation is formed at acceptance
  task automatic send_item(input logic [1:0] m, input logic [29:0] op);
    in_item_t it;
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    it.mode = m;
    it.operand = op;
    in_valid <= 1'b1;
    in_data <= it;
    // in_stall follows registered state only, so it is settled at the falling edge
    forever begin
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
      @(negedge clk);
    end
    expected_q.push_back(predict_multiset(it));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic write_threshold(input logic [29:0] t);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4100) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    thresh = longint'(t);
  endtask

  typedef struct {
    logic [1:0]  m;
    logic [29:0] op;
    bit          typed;
    logic signed [31:0] val;
    logic [1:0]  st;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{MODE_QUERY,  30'd0,          1, -32'sd1, ST_NOT_FOUND},
    '{MODE_QUERY,  30'd1,          1, -32'sd1, ST_NOT_FOUND},
    '{MODE_INSERT, 30'h3FFFFFFF,   1, 32'sd0,  ST_OK},
    '{MODE_INSERT, 30'd0,          1, 32'sd0,  ST_OK},
    '{MODE_INSERT, 30'd0,          1, 32'sd0,  ST_OK},
    '{MODE_QUERY,  30'd1,          1, 32'sh3FFFFFFF, ST_OK},
    '{MODE_QUERY,  30'd3,          1, 32'sd0,  ST_OK},
    '{MODE_QUERY,  30'h3FFFFFFF,   1, -32'sd1, ST_NOT_FOUND},
    '{MODE_RAISE,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_RAISE,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_RAISE,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_QUERY,  30'd1,          0, 0, 0},
    '{MODE_LOWER,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_LOWER,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_LOWER,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_LOWER,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_LOWER,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_QUERY,  30'd2,          0, 0, 0},
    '{MODE_RAISE,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_RAISE,  30'h3FFFFFFF,   0, 0, 0},
    '{MODE_QUERY,  30'd1,          0, 0, 0}
  };

  task automatic random_batch(input int n, input int span);
    int k;
    logic [1:0] m;
    logic [29:0] op;
    for (k = 0; k < n; k++) begin
      m = 2'($urandom_range(3));
      case ($urandom_range(9))
        0: op = 30'($urandom());
        1: op = 30'h3FFFFFFF;
        2: op = 30'($urandom_range(2));
        default: op = 30'(thresh) + 30'($urandom_range(span));
      endcase
      if (m == MODE_INSERT && $urandom_range(3) != 0)
        op = 30'(thresh) + 30'($urandom_range(span));
      if (m == MODE_RAISE || m == MODE_LOWER) begin
        if ($urandom_range(7) != 0) op = 30'($urandom_range(span / 8 + 1));
      end
      if (m == MODE_QUERY && $urandom_range(3) != 0)
        op = 30'($urandom_range(store_vals.size() + 1));
      send_item(m, op);
    end
  endtask

  initial begin
    dir_row_t row;
    int fills;
    offset_acc = 0;
    evict_cnt = 0;
    thresh = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.m, row.op);
      if (row.typed) begin
        // typed rows cross-check the predictor against the table
        if (expected_q[$].result_value !== row.val) begin
          $error("result_value: expected %0d actual %0d (table row %0d)", row.val,
                 expected_q[$].result_value, i);
          errors++;
        end
        if (expected_q[$].status !== row.st) begin
          $error("status: expected %0d actual %0d (table row %0d)", row.st,
                 expected_q[$].status, i);
          errors++;
        end
      end
    end

    write_threshold(30'h3FFFFFFF);
    send_item(MODE_INSERT, 30'h3FFFFFFE);
    send_item(MODE_INSERT, 30'h3FFFFFFF);
    send_item(MODE_LOWER, 30'd1);
    write_threshold(30'd1000);
    send_item(MODE_INSERT, 30'd999);

    // fill to capacity, then a full insert
    send_idle_pct = 0; recv_idle_pct = 0;
    fills = CAPACITY - store_vals.size();
    for (int k = 0; k < fills; k++)
      send_item(MODE_INSERT, 30'd1000 + 30'($urandom_range(5000)));
    send_item(MODE_INSERT, 30'd2000);
    send_item(MODE_QUERY, 30'(CAPACITY));
    send_item(MODE_RAISE, 30'd0);
    send_item(MODE_LOWER, 30'd3000);

    write_threshold(30'd0);
    send_idle_pct = 34; recv_idle_pct = 62;
    random_batch(250, 4000);
    write_threshold(30'($urandom_range(3000)));
    send_idle_pct = 62; recv_idle_pct = 34;
    random_batch(250, 4000);
    write_threshold(30'd50);
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_arm = 1'b1;
    random_batch(250, 4000);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4100) @(negedge clk);
    $display("sent %0d items, checked %0d results over three idle mixes", n_sent, n_recv);
    $display("covered thresholds 0, max and mid, full store, offset saturation");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
